// File: src/fspd_pkg.sv
// Package for the flight stick packet decoder: packet types, length table,
// result groups, the shared packet and result structs and the axis value helper.
// No dependencies.
package fspd_pkg;

  localparam int BUTTON_COUNT = 4;
  localparam int FRAME_KEEP   = 4;

  typedef enum logic [2:0] {
    PKT_NONE0   = 3'd0,
    PKT_BUTTONS = 3'd1,
    PKT_LONG    = 3'd2,
    PKT_STICK   = 3'd3,
    PKT_SKIP    = 3'd4,
    PKT_AXES    = 3'd5,
    PKT_NONE6   = 3'd6,
    PKT_NONE7   = 3'd7
  } pkt_type_t;

  typedef enum logic [1:0] {
    GRP_BUTTONS = 2'd0,
    GRP_STICK   = 2'd1,
    GRP_AXES    = 2'd2
  } grp_t;

  localparam logic [7:0] START_MASK = 8'h80;
  localparam logic [7:0] FLAG_A_LO  = 8'h01;
  localparam logic [7:0] FLAG_B_LO  = 8'h02;
  localparam logic [7:0] FLAG_A_HI  = 8'h04;
  localparam logic [7:0] FLAG_B_HI  = 8'h08;

  // Completed packet handed from the framer to the decoder
  typedef struct packed {
    logic       done;
    pkt_type_t  ptype;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
  } frame_t;

  typedef struct packed {
    logic       valid;
    logic [9:0] stick_x;
    logic [8:0] stick_y;
    logic [8:0] throttle_value;
    logic [8:0] dial_value;
    logic [3:0] hat_bits;
    logic [3:0] button_bits;
    grp_t       updated_group;
  } result_t;

  function automatic logic [3:0] type_len(pkt_type_t t);
    logic [3:0] len;
    unique case (t)
      PKT_BUTTONS: len = 4'd4;
      PKT_LONG:    len = 4'd12;
      PKT_STICK:   len = 4'd3;
      PKT_SKIP:    len = 4'd4;
      PKT_AXES:    len = 4'd4;
      default:     len = 4'd0;
    endcase
    return len;
  endfunction

  // low + 128 when flag a - 256 when flag b, in 10-bit two's complement
  function automatic logic [9:0] raw_value(logic [7:0] lo, logic add128, logic sub256);
    logic [9:0] v;
    v = {2'b00, lo} + (add128 ? 10'd128 : 10'd0) - (sub256 ? 10'd256 : 10'd0);
    return v;
  endfunction

endpackage

// File: src/fspd_framer.sv
// Packet framer: tracks the open packet, keeps its first four bytes and flags
// the byte that completes it. Depends on fspd_pkg.
module fspd_framer
  import fspd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] rx_byte,
  output frame_t     frame
);

  logic [3:0] frame_count_r, frame_count_nxt;
  logic [3:0] frame_length_r, frame_length_nxt;
  logic [7:0] frame_bytes_r [FRAME_KEEP];

  logic       is_start;
  pkt_type_t  start_type;
  logic [3:0] len0;
  logic [3:0] cnt0;
  logic [3:0] cnt1;
  logic       take;
  logic       store;
  logic       done;
  logic [7:0] view [FRAME_KEEP];

  always_comb begin
    is_start   = (rx_byte & START_MASK) != 8'h00;
    start_type = pkt_type_t'(rx_byte[6:4]);
    len0       = is_start ? type_len(start_type) : frame_length_r;
    cnt0       = is_start ? 4'd0 : frame_count_r;
    take       = step && (len0 != 4'd0);
    store      = take && (cnt0[3:2] == 2'b00);
    cnt1       = cnt0 + 4'd1;
    done       = take && (cnt1 == len0);

    frame_count_nxt  = frame_count_r;
    frame_length_nxt = frame_length_r;
    if (step) begin
      if (!take || done) begin
        frame_count_nxt  = 4'd0;
        frame_length_nxt = is_start || done ? 4'd0 : frame_length_r;
      end else begin
        frame_count_nxt  = cnt1;
        frame_length_nxt = len0;
      end
    end

    // the completing byte joins the stored ones in the same cycle
    for (int i = 0; i < FRAME_KEEP; i++) begin
      view[i] = (store && (cnt0[1:0] == 2'(i))) ? rx_byte : frame_bytes_r[i];
    end

    frame.done  = done;
    frame.ptype = pkt_type_t'(view[0][6:4]);
    frame.b0    = view[0];
    frame.b1    = view[1];
    frame.b2    = view[2];
    frame.b3    = view[3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r  <= 4'd0;
      frame_length_r <= 4'd0;
    end else begin
      frame_count_r  <= frame_count_nxt;
      frame_length_r <= frame_length_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (store) begin
      frame_bytes_r[cnt0[1:0]] <= rx_byte;
    end
  end

  a_closed_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (frame_length_r == 4'd0) |-> (frame_count_r == 4'd0))
    else $error("count nonzero with no open packet");

  a_count_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    (frame_length_r != 4'd0) |-> (frame_count_r < frame_length_r))
    else $error("count reached packet length without closing");

  a_len_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (frame_length_r == 4'd0) || (frame_length_r == 4'd3) ||
    (frame_length_r == 4'd4) || (frame_length_r == 4'd12))
    else $error("illegal packet length held");

endmodule

// File: src/fspd_decode.sv
// Packet decoder: applies a completed packet to the held control values and
// forms the result snapshot. Depends on fspd_pkg.
module fspd_decode
  import fspd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  frame_t  frame,
  output result_t result
);

  logic [9:0] stick_x_r, stick_x_nxt;
  logic [8:0] stick_y_r, stick_y_nxt;
  logic [8:0] throttle_r, throttle_nxt;
  logic [8:0] dial_r, dial_nxt;
  logic [3:0] hat_r, hat_nxt;
  logic [3:0] buttons_r, buttons_nxt;

  logic [9:0] v_lo;
  logic [9:0] v_hi;
  logic       hit;
  grp_t       grp;

  always_comb begin
    v_lo = raw_value(frame.b1, (frame.b0 & FLAG_A_LO) != 8'h00,
                     (frame.b0 & FLAG_B_LO) != 8'h00);
    v_hi = raw_value(frame.b2, (frame.b0 & FLAG_A_HI) != 8'h00,
                     (frame.b0 & FLAG_B_HI) != 8'h00);

    stick_x_nxt  = stick_x_r;
    stick_y_nxt  = stick_y_r;
    throttle_nxt = throttle_r;
    dial_nxt     = dial_r;
    hat_nxt      = hat_r;
    buttons_nxt  = buttons_r;
    hit          = 1'b0;
    grp          = GRP_BUTTONS;

    if (frame.done) begin
      unique case (frame.ptype)
        PKT_BUTTONS: begin
          for (int i = 0; i < 4; i++) begin
            if (i < BUTTON_COUNT) begin
              buttons_nxt[i] = frame.b3[i];
            end
          end
          hit = 1'b1;
          grp = GRP_BUTTONS;
        end
        PKT_STICK: begin
          stick_x_nxt = 10'd0 - v_hi;
          stick_y_nxt = v_lo[8:0];
          hit         = 1'b1;
          grp         = GRP_STICK;
        end
        PKT_AXES: begin
          throttle_nxt = v_lo[8:0];
          dial_nxt     = v_hi[8:0];
          // remap byte bits to up, down, left, right
          hat_nxt      = {frame.b3[1], frame.b3[0], frame.b3[3], frame.b3[2]};
          hit          = 1'b1;
          grp          = GRP_AXES;
        end
        default: begin
          hit = 1'b0;
        end
      endcase
    end

    result.valid          = hit;
    result.stick_x        = stick_x_nxt;
    result.stick_y        = stick_y_nxt;
    result.throttle_value = throttle_nxt;
    result.dial_value     = dial_nxt;
    result.hat_bits       = hat_nxt;
    result.button_bits    = buttons_nxt;
    result.updated_group  = grp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stick_x_r  <= 10'd0;
      stick_y_r  <= 9'd0;
      throttle_r <= 9'd0;
      dial_r     <= 9'd0;
      hat_r      <= 4'd0;
      buttons_r  <= 4'd0;
    end else begin
      stick_x_r  <= stick_x_nxt;
      stick_y_r  <= stick_y_nxt;
      throttle_r <= throttle_nxt;
      dial_r     <= dial_nxt;
      hat_r      <= hat_nxt;
      buttons_r  <= buttons_nxt;
    end
  end

endmodule

// File: src/flight_stick_packet_decoder_core.sv
// Top level of the flight stick packet decoder: input word register, framer,
// decoder and output register. Depends on fspd_pkg, fspd_framer, fspd_decode.
//
//  channel | dir | payload
//  in_     | in  | tdata[7:0] rx_byte
//  out_    | out | tdata stick_x, stick_y, throttle, dial, hat, buttons; tuser group
//
// One word enters per cycle while the output is not stalled; a completing byte passes
// from the input register through the framer and decoder into the output register.
// Framing and decoding are a single pass of logic between the two registers.
// Synchronous active-low reset clears control state and the held values.
// A stalled output holds the input register; in_tready drops only then.
module flight_stick_packet_decoder_core
  import fspd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [9:0] stick_x, [18:10] stick_y, [27:19] throttle_value,
                                  // [36:28] dial_value, [40:37] hat_bits,
                                  // [44:41] button_bits, [47:45] zero
  output logic [1:0]  out_tuser   // [1:0] updated_group
);

  logic       in_valid_r, in_valid_nxt;
  logic [7:0] in_byte_r;
  logic       out_valid_r, out_valid_nxt;
  result_t    out_r;
  logic       adv;
  logic       step;
  frame_t     frame;
  result_t    result;

  assign adv       = !out_valid_r || out_tready;
  assign step      = in_valid_r && adv;
  assign in_tready = !in_valid_r || adv;

  fspd_framer u_framer (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (in_byte_r),
    .frame   (frame)
  );

  fspd_decode u_decode (
    .clk    (clk),
    .rst_n  (rst_n),
    .frame  (frame),
    .result (result)
  );

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_tvalid && in_tready) begin
      in_valid_nxt = 1'b1;
    end else if (step) begin
      in_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r && !out_tready;
    if (step && result.valid) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
    if (step && result.valid) begin
      out_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_r.button_bits, out_r.hat_bits, out_r.dial_value,
                       out_r.throttle_value, out_r.stick_y, out_r.stick_x};
  assign out_tuser  = out_r.updated_group;

  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with output register empty");

  a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !adv) |=> (in_valid_r && $stable(in_byte_r)))
    else $error("held input word lost during stall");

  a_group_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_tuser != 2'd3))
    else $error("illegal update group on output");

endmodule

// File: bench/flight_stick_packet_decoder_core_test.sv
`timescale 1ns / 100ps
// Self-checking bench for flight_stick_packet_decoder_core: streams serial bytes in,
// predicts each control snapshot and compares it per field. Depends on fspd_pkg and flight_stick_packet_decoder_core.
module flight_stick_packet_decoder_core_test;
  import fspd_pkg::*;

  localparam logic [3:0] LEN_OF [8] = '{4'd0, 4'd4, 4'd12, 4'd3, 4'd4, 4'd4, 4'd0, 4'd0};
  localparam logic [8:0] DRAIN      = 9'h100;
  localparam int         RX_ITEMS   = 550;

  typedef struct packed {
    logic [9:0] x;
    logic [8:0] y;
    logic [8:0] thr;
    logic [8:0] dial;
    logic [3:0] hat;
    logic [3:0] btn;
    grp_t       grp;
  } ctrl_snapshot_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [1:0]  out_tuser;

  // bit 8 set marks a hold until every snapshot has come back
  logic [8:0]     rx_pending[$];
  ctrl_snapshot_t snapshots_due[$];
  int             fail_count = 0;
  int             gap_left   = 0;
  int             stall_left = 0;
  bit             feed_calm  = 1'b0;
  bit             sink_calm  = 1'b0;

  // predictor state
  logic [3:0] pkt_len    = '0;
  logic [3:0] pkt_count  = '0;
  logic [7:0] pkt_bytes [4];
  logic [9:0] held_x     = '0;
  logic [9:0] held_y     = '0;
  logic [9:0] held_thr   = '0;
  logic [9:0] held_dial  = '0;
  logic [3:0] held_hat   = '0;
  logic [3:0] held_btn   = '0;

  flight_stick_packet_decoder_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic int axis_word(logic [7:0] lo, logic plus128, logic minus256);
    return int'(lo) + (plus128 ? 128 : 0) - (minus256 ? 256 : 0);
  endfunction

  function automatic void decode_packet();
    ctrl_snapshot_t snap;
    pkt_type_t      kind;
    logic [7:0]     b0;
    logic [7:0]     b3;
    int             i;
    b0   = pkt_bytes[0];
    b3   = pkt_bytes[3];
    kind = pkt_type_t'(b0[6:4]);
    snap = '0;
    case (kind)
      PKT_BUTTONS: begin
        for (i = 0; i < BUTTON_COUNT && i < 4; i++) held_btn[i] = b3[i];
        snap.grp = GRP_BUTTONS;
      end
      PKT_STICK: begin
        held_x = 10'(-axis_word(pkt_bytes[2], (b0 & FLAG_A_HI) != 0, (b0 & FLAG_B_HI) != 0));
        held_y = 10'(axis_word(pkt_bytes[1], (b0 & FLAG_A_LO) != 0, (b0 & FLAG_B_LO) != 0));
        snap.grp = GRP_STICK;
      end
      PKT_AXES: begin
        held_thr  = 10'(axis_word(pkt_bytes[1], (b0 & FLAG_A_LO) != 0,
                                  (b0 & FLAG_B_LO) != 0));
        held_dial = 10'(axis_word(pkt_bytes[2], (b0 & FLAG_A_HI) != 0,
                                  (b0 & FLAG_B_HI) != 0));
        // up, down, left, right from byte 3 bits 2, 3, 0, 1
        held_hat  = {b3[1], b3[0], b3[3], b3[2]};
        snap.grp  = GRP_AXES;
      end
      default: return;
    endcase
    snap.x    = held_x;
    snap.y    = held_y[8:0];
    snap.thr  = held_thr[8:0];
    snap.dial = held_dial[8:0];
    snap.hat  = held_hat;
    snap.btn  = held_btn;
    snapshots_due.push_back(snap);
  endfunction

  function automatic void take_rx_byte(logic [7:0] b);
    if ((b & START_MASK) != 0) begin
      pkt_count = '0;
      pkt_len   = LEN_OF[b[6:4]];
      if (pkt_len == 0) return;
    end else if (pkt_len == 0) begin
      return;
    end
    if (pkt_count < 4) pkt_bytes[pkt_count[1:0]] = b;
    pkt_count = pkt_count + 4'd1;
    if (pkt_count == pkt_len) begin
      decode_packet();
      pkt_count = '0;
      pkt_len   = '0;
    end
  endfunction

  task automatic check_field(string what, int want, int got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, what, want, got);
      fail_count++;
    end
  endtask

  // feed bytes from the pending queue
  always @(posedge clk) begin : feed_proc
    logic       holding;
    logic [8:0] next_word;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      holding = in_tvalid && !in_tready;
      if (in_tvalid && in_tready) take_rx_byte(in_tdata);
      if (!holding) begin
        if (gap_left > 0 || rx_pending.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_tvalid <= 1'b0;
        end else if (rx_pending[0] == DRAIN) begin
          in_tvalid <= 1'b0;
          if (snapshots_due.size() == 0) void'(rx_pending.pop_front());
        end else begin
          next_word = rx_pending.pop_front();
          in_tdata  <= next_word[7:0];
          in_tvalid <= 1'b1;
          gap_left = feed_calm ? 0 : $urandom_range(0, 12);
          if ($urandom_range(0, 29) == 0) feed_calm = !feed_calm;
        end
      end
    end
  end

  // take snapshots and compare against the oldest prediction
  always @(posedge clk) begin : sink_proc
    ctrl_snapshot_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (snapshots_due.size() == 0) begin
          $display("%0t ns: unexpected snapshot, expected none actual %h group %0d",
                   $time, out_tdata, out_tuser);
          fail_count++;
        end else begin
          want = snapshots_due.pop_front();
          check_field("stick_x", want.x, out_tdata[9:0]);
          check_field("stick_y", want.y, out_tdata[18:10]);
          check_field("throttle_value", want.thr, out_tdata[27:19]);
          check_field("dial_value", want.dial, out_tdata[36:28]);
          check_field("hat_bits", want.hat, out_tdata[40:37]);
          check_field("button_bits", want.btn, out_tdata[44:41]);
          check_field("tdata pad", 0, out_tdata[47:45]);
          check_field("updated_group", want.grp, out_tuser);
        end
        stall_left = sink_calm ? 0 : $urandom_range(0, 12);
        if ($urandom_range(0, 19) == 0) sink_calm = !sink_calm;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    #500_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stim_proc
    logic [7:0] directed [] = '{
      8'h00,                                  // stray data, no packet open
      8'h90, 8'h55, 8'h2A, 8'h0F,             // buttons all pressed
      8'hBF, 8'h7F, 8'h00,                    // stick, every flag set
      8'hDF, 8'h7F, 8'h00, 8'h0F,             // axes, every flag and hat bit
      8'hA0, 8'h7F, 8'h00, 8'h01, 8'h02, 8'h03, // long packet, twelve bytes
      8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09,
      8'h90, 8'h01, 8'hF0                     // zero-length start closes open packet
    };
    pkt_type_t kind;
    int        queued;
    int        next_drain;
    int        len;
    int        roll;
    int        i;
    foreach (directed[k]) rx_pending.push_back({1'b0, directed[k]});
    rx_pending.push_back(DRAIN);
    queued     = directed.size();
    next_drain = 180;
    while (queued < RX_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        rx_pending.push_back({1'b0, 8'($urandom)});
        queued++;
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2: kind = PKT_BUTTONS;
          3, 4, 5: kind = PKT_STICK;
          6, 7:    kind = PKT_AXES;
          8:       kind = $urandom_range(0, 1) ? PKT_LONG : PKT_SKIP;
          default: begin
            case ($urandom_range(0, 2))
              0:       kind = PKT_NONE0;
              1:       kind = PKT_NONE6;
              default: kind = PKT_NONE7;
            endcase
          end
        endcase
        len = LEN_OF[kind];
        // cut some packets short so the next start drops them
        if (roll < 18 && len > 1) len = $urandom_range(1, len - 1);
        rx_pending.push_back({2'b01, kind, 4'($urandom)});
        queued++;
        for (i = 1; i < len; i++) begin
          rx_pending.push_back({2'b00, 7'($urandom)});
          queued++;
        end
      end
      if (queued >= next_drain) begin
        rx_pending.push_back(DRAIN);
        next_drain += 180;
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    while (rx_pending.size() != 0 || in_tvalid || snapshots_due.size() != 0)
      @(negedge clk);
    repeat (8) @(posedge clk);
    if (snapshots_due.size() != 0) begin
      $display("%0t ns: %0d snapshots never arrived, expected 0 actual %0d",
               $time, snapshots_due.size(), snapshots_due.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
